FILE: rtl/core/circle_pair_tangent_points_top_assert.svh
// Assertion macros for the tangent point block checker
`ifndef CIRCLE_PAIR_TANGENT_POINTS_TOP_ASSERT_SVH
`define CIRCLE_PAIR_TANGENT_POINTS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CPTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cptp_pkg.sv
// Shared widths, types and constants of the tangent point block
package cptp_pkg;

  localparam int CW     = 32;          // coordinate width
  localparam int FB     = 12;          // fraction bits, binary point only
  localparam int RW     = 28;          // radius width
  localparam int TW     = 12;          // tolerance register width
  localparam int NW     = 30;          // deltas held below 2^NW
  localparam int MAGW   = CW + 1;
  localparam int EXTW   = (MAGW > NW) ? MAGW : NW;
  localparam int KW     = $clog2(EXTW - NW + 2);
  localparam int D2W    = 2 * NW + 1;
  localparam int HW     = NW + 1;      // square root result width
  localparam int SRW    = 2 * HW;      // radicand width
  localparam int AW     = 2 * (HW + 1);
  localparam int QSTEPS = NW + 1;
  localparam int QW     = QSTEPS + 1;
  localparam int FW     = QSTEPS;
  localparam int DVL    = QSTEPS + 1;  // divider stages
  localparam int OPW    = RW + FW;
  localparam int OMW    = OPW + 1 - NW;
  localparam int SUMW   = ((CW > OMW) ? CW : OMW) + 2;
  localparam int INW    = ((4 * CW + 2 * RW + 7) / 8) * 8;
  localparam int OUTW   = ((8 * CW + 7) / 8) * 8;
  localparam int LAT    = 4 + HW + 3 + DVL + 3;
  localparam int LANES  = 4;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [RW-1:0]        rad_t;
  typedef logic [D2W-1:0]       d2_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t qx;
    coord_t qy;
    rad_t   r1;
    rad_t   r2;
    logic   degen;
  } base_t;

  typedef struct packed {
    base_t        b;
    logic [NW-1:0] mx;
    logic [NW-1:0] my;
    logic [NW-1:0] mr;
    logic         sx;
    logic         sy;
    d2_t          d2;
  } geo_t;

  typedef struct packed {
    base_t            b;
    logic [LANES-1:0] neg;
  } tail_t;

endpackage

FILE: rtl/core/cptp_sqrt.sv
// Pipelined integer square root, one result bit per stage
module cptp_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cptp_pkg::SRW-1:0]   rad,
  output logic [cptp_pkg::HW-1:0]    root
);
  import cptp_pkg::*;

  logic [SRW-1:0] rem_r [HW];
  logic [SRW-1:0] res_r [HW];

  for (genvar j = 0; j < HW; j++) begin : g_stg
    localparam logic [SRW-1:0] BIT = SRW'(1) << (2 * (HW - 1 - j));
    logic [SRW-1:0] rin, sin, trial, rem_nxt, res_nxt;

    always_comb begin
      rin   = (j == 0) ? rad : rem_r[(j == 0) ? 0 : j - 1];
      sin   = (j == 0) ? '0  : res_r[(j == 0) ? 0 : j - 1];
      trial = sin + BIT;
      if (rin >= trial) begin
        rem_nxt = rin - trial;
        res_nxt = (sin >> 1) + BIT;
      end else begin
        rem_nxt = rin;
        res_nxt = sin >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        res_r[j] <= res_nxt;
      end
    end
  end

  assign root = res_r[HW-1][HW-1:0];

endmodule

FILE: rtl/core/cptp_div.sv
// Pipelined fraction divider: num * 2^31 / den truncated, num clamped to den
module cptp_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cptp_pkg::AW-2:0]    num,
  input  cptp_pkg::d2_t              den,
  output logic [cptp_pkg::QW-1:0]    quo
);
  import cptp_pkg::*;

  logic [D2W-1:0] rem_r [DVL];
  logic [D2W-1:0] den_r [DVL];
  logic [QW-1:0]  q_r   [DVL];

  logic           ge0;
  assign ge0 = num >= (AW-1)'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      q_r[0]   <= QW'(ge0);
      rem_r[0] <= ge0 ? '0 : num[D2W-1:0];
    end
  end

  for (genvar j = 1; j < DVL; j++) begin : g_stp
    logic [D2W:0]   rs;
    logic [D2W-1:0] rem_nxt;
    logic [QW-1:0]  q_nxt;

    always_comb begin
      rs = {rem_r[j-1], 1'b0};
      if (rs >= (D2W+1)'(den_r[j-1])) begin
        rem_nxt = D2W'(rs - (D2W+1)'(den_r[j-1]));
        q_nxt   = {q_r[j-1][QW-2:0], 1'b1};
      end else begin
        rem_nxt = rs[D2W-1:0];
        q_nxt   = {q_r[j-1][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[DVL-1];

endmodule

FILE: rtl/core/circle_pair_tangent_points_top.sv
// Outer common tangent points of two circles, fixed-point pipeline
//
// Input beat (in_*): two circles, each a Q19.12 centre and a Q16.12 radius.
// Result beat (out_*): the four outer tangent points, larger circle first,
// and a status flag in out_tuser (1 = coincident or nested, points zero).
// cfg_*: one write channel for the equal-radius tolerance, always ready;
// write it only while no beat is in flight.
// The path from an accepted input beat to out_tvalid runs through four front
// stages, a 31-stage square root, three product stages, a 32-stage divider
// (four lanes) and three output stages. One beat enters every cycle unless stalled.
// The whole pipeline advances together; it stalls only when the output
// register holds a beat that out_tready does not take, and then in_tready
// drops in the same cycle. Nothing is lost or repeated across a stall.
// Synchronous reset clears all valid bits and sets the tolerance to zero.
module circle_pair_tangent_points_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // lsb up: center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b
  input  logic [cptp_pkg::INW-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // lsb up: big_left_x, big_left_y, big_right_x, big_right_y,
  //         small_left_x, small_left_y, small_right_x, small_right_y
  output logic [cptp_pkg::OUTW-1:0]  out_tdata,
  // status
  output logic                       out_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cptp_pkg::TW-1:0]    cfg_data
);
  import cptp_pkg::*;

  localparam int OFF_AY = CW;
  localparam int OFF_RA = 2 * CW;
  localparam int OFF_BX = 2 * CW + RW;
  localparam int OFF_BY = 3 * CW + RW;
  localparam int OFF_RB = 4 * CW + RW;
  localparam logic [OPW:0] HALF = (OPW+1)'(1) << (NW - 1);

  function automatic coord_t sat(input logic signed [SUMW-1:0] s);
    logic signed [SUMW-1:0] hi, lo;
    hi = $signed({{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    lo = -hi - SUMW'(1);
    if (s > hi)      return hi[CW-1:0];
    else if (s < lo) return lo[CW-1:0];
    else             return s[CW-1:0];
  endfunction

  logic en;
  logic [TW-1:0] tol_r;

  // valid bits
  logic v1_r, v2_r, v3_r, v4_r, vp_r, va_r, vm_r, vr_r, vx_r, vo_r;
  logic vd_r [HW];
  logic vq_r [DVL];

  assign en        = !vo_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // ---- stage 1: order by radius, centre deltas
  coord_t ax, ay, bx, by;
  rad_t   ra, rb;
  logic   swap;
  base_t  s1_b_nxt, s1_b_r;
  rad_t   dr, s1_mr_nxt, s1_mr_r;
  logic   s1_eq_nxt, s1_eq_r;
  logic signed [CW:0] s1_dx_nxt, s1_dy_nxt, s1_dx_r, s1_dy_r;

  assign ax = in_tdata[CW-1:0];
  assign ay = in_tdata[OFF_AY +: CW];
  assign ra = in_tdata[OFF_RA +: RW];
  assign bx = in_tdata[OFF_BX +: CW];
  assign by = in_tdata[OFF_BY +: CW];
  assign rb = in_tdata[OFF_RB +: RW];

  always_comb begin
    swap           = ra < rb;
    s1_b_nxt.px    = swap ? bx : ax;
    s1_b_nxt.py    = swap ? by : ay;
    s1_b_nxt.r1    = swap ? rb : ra;
    s1_b_nxt.qx    = swap ? ax : bx;
    s1_b_nxt.qy    = swap ? ay : by;
    s1_b_nxt.r2    = swap ? ra : rb;
    s1_b_nxt.degen = 1'b0;
    dr             = s1_b_nxt.r1 - s1_b_nxt.r2;
    s1_eq_nxt      = dr <= RW'(tol_r);
    s1_mr_nxt      = s1_eq_nxt ? '0 : dr;
    s1_dx_nxt = $signed({s1_b_nxt.qx[CW-1], s1_b_nxt.qx}) -
                $signed({s1_b_nxt.px[CW-1], s1_b_nxt.px});
    s1_dy_nxt = $signed({s1_b_nxt.qy[CW-1], s1_b_nxt.qy}) -
                $signed({s1_b_nxt.py[CW-1], s1_b_nxt.py});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b_r  <= s1_b_nxt;
      s1_mr_r <= s1_mr_nxt;
      s1_eq_r <= s1_eq_nxt;
      s1_dx_r <= s1_dx_nxt;
      s1_dy_r <= s1_dy_nxt;
    end
  end

  // ---- stage 2: magnitudes, common right shift until all below 2^NW
  logic [CW:0]    mxa, mya;
  logic [EXTW-1:0] mxe, mye, mre, orv;
  logic [KW-1:0]  k;
  logic [NW-1:0]  s2_mx_nxt, s2_my_nxt, s2_mr_nxt, s2_mx_r, s2_my_r, s2_mr_r;
  logic           s2_sx_r, s2_sy_r, s2_eq_r;
  base_t          s2_b_r;

  always_comb begin
    mxa = s1_dx_r[CW] ? unsigned'(-s1_dx_r) : unsigned'(s1_dx_r);
    mya = s1_dy_r[CW] ? unsigned'(-s1_dy_r) : unsigned'(s1_dy_r);
    mxe = EXTW'(mxa);
    mye = EXTW'(mya);
    mre = EXTW'(s1_mr_r);
    orv = mxe | mye | mre;
    k   = '0;
    for (int b = NW; b < EXTW; b++) begin
      if (orv[b]) k = KW'(b - NW + 1);
    end
    s2_mx_nxt = NW'(mxe >> k);
    s2_my_nxt = NW'(mye >> k);
    s2_mr_nxt = NW'(mre >> k);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mx_r <= s2_mx_nxt;
      s2_my_r <= s2_my_nxt;
      s2_mr_r <= s2_mr_nxt;
      s2_sx_r <= s1_dx_r[CW];
      s2_sy_r <= s1_dy_r[CW];
      s2_eq_r <= s1_eq_r;
      s2_b_r  <= s1_b_r;
    end
  end

  // ---- stage 3: squares
  logic [2*NW-1:0] s3_sqx_r, s3_sqy_r, s3_sqr_r;
  logic [NW-1:0]   s3_mx_r, s3_my_r, s3_mr_r;
  logic            s3_sx_r, s3_sy_r, s3_eq_r;
  base_t           s3_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx_r <= s2_mx_r * s2_mx_r;
      s3_sqy_r <= s2_my_r * s2_my_r;
      s3_sqr_r <= s2_mr_r * s2_mr_r;
      s3_mx_r  <= s2_mx_r;
      s3_my_r  <= s2_my_r;
      s3_mr_r  <= s2_mr_r;
      s3_sx_r  <= s2_sx_r;
      s3_sy_r  <= s2_sy_r;
      s3_eq_r  <= s2_eq_r;
      s3_b_r   <= s2_b_r;
    end
  end

  // ---- stage 4: |d|^2, degenerate test, radicand
  d2_t            d2;
  logic           degen;
  geo_t           s4_g_nxt, s4_g_r;
  logic [SRW-1:0] s4_rad_nxt, s4_rad_r;

  always_comb begin
    d2    = D2W'(s3_sqx_r) + D2W'(s3_sqy_r);
    degen = (d2 == '0) || (!s3_eq_r && (d2 < D2W'(s3_sqr_r)));
    s4_g_nxt.b       = s3_b_r;
    s4_g_nxt.b.degen = degen;
    s4_g_nxt.mx      = s3_mx_r;
    s4_g_nxt.my      = s3_my_r;
    s4_g_nxt.mr      = s3_mr_r;
    s4_g_nxt.sx      = s3_sx_r;
    s4_g_nxt.sy      = s3_sy_r;
    s4_g_nxt.d2      = d2;
    s4_rad_nxt = degen ? '0 : SRW'(d2 - D2W'(s3_sqr_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_g_r   <= s4_g_nxt;
      s4_rad_r <= s4_rad_nxt;
    end
  end

  // ---- square root, geometry rides alongside
  logic [HW-1:0] h;
  geo_t          gd_r [HW];

  cptp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad_r),
    .root (h)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      gd_r[0] <= s4_g_r;
      for (int i = 1; i < HW; i++) gd_r[i] <= gd_r[i-1];
    end
  end

  // ---- products stage
  geo_t g;
  logic signed [HW:0]   drs, dxs, dys, hs;
  logic signed [AW-1:0] p_nxt [LANES];
  logic signed [AW-1:0] p_r   [LANES];
  base_t                p_b_r;
  d2_t                  p_d2_r;

  always_comb begin
    g   = gd_r[HW-1];
    drs = $signed((HW+1)'(g.mr));
    dxs = g.sx ? -$signed((HW+1)'(g.mx)) : $signed((HW+1)'(g.mx));
    dys = g.sy ? -$signed((HW+1)'(g.my)) : $signed((HW+1)'(g.my));
    hs  = $signed({1'b0, h});
    p_nxt[0] = drs * dxs;
    p_nxt[1] = hs * dys;
    p_nxt[2] = drs * dys;
    p_nxt[3] = hs * dxs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) p_r[i] <= p_nxt[i];
      p_b_r  <= g.b;
      p_d2_r <= g.d2;
    end
  end

  // ---- sums: left x, left y, right x, right y
  logic signed [AW-1:0] a_r [LANES];
  base_t                a_b_r;
  d2_t                  a_d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= p_r[0] + p_r[1];
      a_r[1] <= p_r[2] - p_r[3];
      a_r[2] <= p_r[0] - p_r[1];
      a_r[3] <= p_r[2] + p_r[3];
      a_b_r  <= p_b_r;
      a_d2_r <= p_d2_r;
    end
  end

  // ---- magnitudes into the dividers
  logic [AW-1:0]    am   [LANES];
  logic [AW-2:0]    m_r  [LANES];
  logic [LANES-1:0] m_neg_r;
  base_t            m_b_r;
  d2_t              m_d2_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      am[i] = a_r[i][AW-1] ? unsigned'(-a_r[i]) : unsigned'(a_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        m_r[i]     <= am[i][AW-2:0];
        m_neg_r[i] <= a_r[i][AW-1];
      end
      m_b_r  <= a_b_r;
      m_d2_r <= a_d2_r;
    end
  end

  logic [QW-1:0] q [LANES];
  tail_t         td_r [DVL];

  for (genvar i = 0; i < LANES; i++) begin : g_div
    cptp_div u_div (
      .clk (clk),
      .en  (en),
      .num (m_r[i]),
      .den (m_d2_r),
      .quo (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0].b   <= m_b_r;
      td_r[0].neg <= m_neg_r;
      for (int i = 1; i < DVL; i++) td_r[i] <= td_r[i-1];
    end
  end

  // ---- round the fractions
  logic [QW:0]   qp  [LANES];
  logic [FW-1:0] f_r [LANES];
  tail_t         r_t_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) qp[i] = (QW+1)'(q[i]) + (QW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) f_r[i] <= qp[i][FW:1];
      r_t_r <= td_r[DVL-1];
    end
  end

  // ---- radius times fraction; outputs 0..3 on the big circle, 4..7 on the small
  logic [OPW-1:0] x_r [2*LANES];
  tail_t          x_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        x_r[i]         <= OPW'(r_t_r.b.r1) * OPW'(f_r[i]);
        x_r[i + LANES] <= OPW'(r_t_r.b.r2) * OPW'(f_r[i]);
      end
      x_t_r <= r_t_r;
    end
  end

  // ---- round, sign, add to the centre, saturate
  logic [OPW:0]           pr  [2*LANES];
  logic [OMW-1:0]         om  [2*LANES];
  logic signed [SUMW-1:0] ctr [2*LANES];
  logic signed [SUMW-1:0] off [2*LANES];
  logic [OUTW-1:0]        o_data_nxt, o_data_r;
  logic                   o_stat_r;

  always_comb begin
    o_data_nxt = '0;
    for (int i = 0; i < 2 * LANES; i++) begin
      pr[i]  = (OPW+1)'(x_r[i]) + HALF;
      om[i]  = pr[i][OPW:NW];
      off[i] = x_t_r.neg[i % LANES] ? -$signed(SUMW'(om[i])) : $signed(SUMW'(om[i]));
      if (i < LANES) begin
        ctr[i] = (i % 2 == 0) ? SUMW'(x_t_r.b.px) : SUMW'(x_t_r.b.py);
      end else begin
        ctr[i] = (i % 2 == 0) ? SUMW'(x_t_r.b.qx) : SUMW'(x_t_r.b.qy);
      end
      if (!x_t_r.b.degen) o_data_nxt[i*CW +: CW] = sat(ctr[i] + off[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data_r <= o_data_nxt;
      o_stat_r <= x_t_r.b.degen;
    end
  end

  assign out_tdata  = o_data_r;
  assign out_tuser  = o_stat_r;
  assign out_tvalid = vo_r;

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      vp_r <= 1'b0; va_r <= 1'b0; vm_r <= 1'b0;
      vr_r <= 1'b0; vx_r <= 1'b0; vo_r <= 1'b0;
      for (int i = 0; i < HW; i++)  vd_r[i] <= 1'b0;
      for (int i = 0; i < DVL; i++) vq_r[i] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int i = 1; i < HW; i++) vd_r[i] <= vd_r[i-1];
      vp_r    <= vd_r[HW-1];
      va_r    <= vp_r;
      vm_r    <= va_r;
      vq_r[0] <= vm_r;
      for (int i = 1; i < DVL; i++) vq_r[i] <= vq_r[i-1];
      vr_r    <= vq_r[DVL-1];
      vx_r    <= vr_r;
      vo_r    <= vx_r;
    end
  end

endmodule

FILE: rtl/core/cptp_checker.sv
// Port-level checks on the tangent point block, bound to the top level
`include "circle_pair_tangent_points_top_assert.svh"

module cptp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [cptp_pkg::INW-1:0]   in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cptp_pkg::OUTW-1:0]  out_tdata,
  input logic                       out_tuser,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [cptp_pkg::TW-1:0]    cfg_data
);
  import cptp_pkg::*;

  // stalled result beat holds
  `CPTP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed under stall")
  // degenerate beats carry zero points
  `CPTP_ASSERT_NOW(a_degen_zero, out_tvalid && out_tuser, out_tdata == '0, "degenerate beat with non-zero points")
  // empty output never blocks input
  `CPTP_ASSERT_NOW(a_ready_free, !out_tvalid, in_tready, "input blocked with empty output")
  // pipeline empty straight after reset
  `CPTP_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_tvalid && cfg_ready, "result valid right after reset")

endmodule

bind circle_pair_tangent_points_top cptp_checker u_cptp_checker (.*);
